// ===== rtl/cht_pkg.sv =====
// Package for the chained hash table unit: sizes, command and status codes,
// and the sequencer state type. It depends on nothing else.
package cht_pkg;

  localparam int unsigned MaxBuckets  = 256;
  localparam int unsigned PoolEntries = 1024;
  localparam int unsigned ValueBits   = 32;
  localparam int unsigned KeyBits     = 32;
  localparam int unsigned BktCntBits  = 9;
  localparam int unsigned BucketBits  = $clog2(MaxBuckets);
  localparam int unsigned PoolBits    = $clog2(PoolEntries);
  localparam int unsigned CountBits   = PoolBits + 1;
  localparam int unsigned StepBits    = $clog2(KeyBits);

  localparam logic [BktCntBits-1:0] BktCntReset = BktCntBits'(MaxBuckets);

  typedef enum logic [1:0] {
    CmdLookup = 2'd0,
    CmdInsert = 2'd1,
    CmdDelete = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StNotFound  = 2'd1,
    StDuplicate = 2'd2,
    StPoolFull  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StDiv,
    StHeadRd,
    StHead,
    StEntry,
    StAct,
    StPop,
    StAlloc,
    StLink,
    StFin
  } state_e;

  // A chain link: a valid flag and the index of the next pool slot.
  typedef struct packed {
    logic                vld;
    logic [PoolBits-1:0] idx;
  } link_t;

endpackage

// ===== rtl/chained_hash_table_unit.sv =====
// Chained hash table unit: a key-value store in on-chip memories.
// It depends on cht_pkg for its sizes, codes and state type.
//
// One command is in flight at a time. An accepted lookup, insert or delete
// first goes through a bit-serial modulo of the key by the bucket count,
// then the bucket head is read, then the chain is walked one entry at a
// time, since each step reads the entry memories and compares the key on the
// registered read data before the next address is issued. An action state
// follows; an insert that adds an entry then pops a recycled slot if there is
// one, writes the entry and, when the chain was not empty, links it, and a
// final state loads the result register. A no-op goes straight to that state.
// The next command is accepted while a result still waits in the output
// register. No clearing pass is needed after reset.
module chained_hash_table_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cht_pkg::BktCntBits-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     command_i,
  input  logic [cht_pkg::KeyBits-1:0]    key_i,
  input  logic [31:0]                    value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [31:0]                    found_value_o
);

  // Configuration register and effective divisor.
  logic [cht_pkg::BktCntBits-1:0] bkt_cnt_q;
  logic [cht_pkg::BktCntBits-1:0] divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkt_cnt_q <= cht_pkg::BktCntReset;
    end else if (cfg_we_i) begin
      bkt_cnt_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (bkt_cnt_q == '0) begin
      divisor = cht_pkg::BktCntBits'(1);
    end else if (bkt_cnt_q > cht_pkg::BktCntBits'(cht_pkg::MaxBuckets)) begin
      divisor = cht_pkg::BktCntBits'(cht_pkg::MaxBuckets);
    end else begin
      divisor = bkt_cnt_q;
    end
  end

  // Control and working registers.
  cht_pkg::state_e state_q, state_d;
  cht_pkg::cmd_e   cmd_q;
  logic [cht_pkg::KeyBits-1:0]    key_q, shift_q, shift_d;
  logic [cht_pkg::ValueBits-1:0]  val_q;
  logic [cht_pkg::BucketBits-1:0] rem_q, rem_d;
  logic [cht_pkg::StepBits-1:0]   step_q;
  logic [cht_pkg::PoolBits-1:0]   cur_q, cur_d, prev_q, prev_d, slot_q, slot_d;
  logic                           prev_ok_q, prev_ok_d, hit_q, hit_d;
  logic [cht_pkg::CountBits-1:0]  freed_cnt_q, freed_cnt_d, fresh_q, fresh_d;
  logic [cht_pkg::MaxBuckets-1:0] head_vld_q;
  logic [1:0]                     res_status_q, res_status_d;
  logic [31:0]                    res_found_q, res_found_d;
  logic                           out_valid_q;
  logic [1:0]                     out_status_q;
  logic [31:0]                    out_found_q;

  // Memory read data registers.
  logic [cht_pkg::PoolBits-1:0]  head_rd_q;
  logic [cht_pkg::KeyBits-1:0]   key_rd_q;
  logic [cht_pkg::ValueBits-1:0] val_rd_q;
  cht_pkg::link_t                link_rd_q;
  logic [cht_pkg::PoolBits-1:0]  freed_rd_q;

  // Memory control.
  logic                          ent_re, freed_re, head_we, ent_we, link_we, freed_we;
  logic [cht_pkg::PoolBits-1:0]  ent_raddr, freed_raddr, head_wdata, link_waddr;
  cht_pkg::link_t                link_wdata;
  logic                          head_vld_wdata;

  // Modulo step: shift in one key bit, subtract the divisor when it fits.
  logic [cht_pkg::BucketBits:0] rem_sh;
  logic                         pool_empty;
  logic                         key_match;

  assign rem_sh     = {rem_q, shift_q[cht_pkg::KeyBits-1]};
  assign pool_empty = (fresh_q == cht_pkg::CountBits'(cht_pkg::PoolEntries)) &&
                      (freed_cnt_q == '0);
  assign key_match  = (key_rd_q == key_q);
  assign in_ready_o = (state_q == cht_pkg::StIdle);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cht_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = (cht_pkg::cmd_e'(command_i) == cht_pkg::CmdNop) ? cht_pkg::StFin
                                                                   : cht_pkg::StDiv;
        end
      end
      cht_pkg::StDiv: begin
        if (step_q == cht_pkg::StepBits'(cht_pkg::KeyBits - 1)) begin
          state_d = cht_pkg::StHeadRd;
        end
      end
      cht_pkg::StHeadRd: state_d = cht_pkg::StHead;
      cht_pkg::StHead: begin
        state_d = head_vld_q[rem_q] ? cht_pkg::StEntry : cht_pkg::StAct;
      end
      cht_pkg::StEntry: begin
        if (key_match || !link_rd_q.vld) begin
          state_d = cht_pkg::StAct;
        end
      end
      cht_pkg::StAct: begin
        if (cmd_q == cht_pkg::CmdInsert && !hit_q && !pool_empty) begin
          state_d = (freed_cnt_q != '0) ? cht_pkg::StPop : cht_pkg::StAlloc;
        end else begin
          state_d = cht_pkg::StFin;
        end
      end
      cht_pkg::StPop:   state_d = cht_pkg::StAlloc;
      cht_pkg::StAlloc: state_d = prev_ok_q ? cht_pkg::StLink : cht_pkg::StFin;
      cht_pkg::StLink:  state_d = cht_pkg::StFin;
      cht_pkg::StFin: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = cht_pkg::StIdle;
        end
      end
      default: state_d = cht_pkg::StIdle;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    shift_d        = shift_q;
    rem_d          = rem_q;
    cur_d          = cur_q;
    prev_d         = prev_q;
    prev_ok_d      = prev_ok_q;
    hit_d          = hit_q;
    slot_d         = slot_q;
    freed_cnt_d    = freed_cnt_q;
    fresh_d        = fresh_q;
    res_status_d   = res_status_q;
    res_found_d    = res_found_q;
    ent_re         = 1'b0;
    ent_raddr      = cur_q;
    freed_re       = 1'b0;
    freed_raddr    = freed_cnt_q[cht_pkg::PoolBits-1:0];
    head_we        = 1'b0;
    head_wdata     = slot_q;
    head_vld_wdata = 1'b1;
    ent_we         = 1'b0;
    link_we        = 1'b0;
    link_waddr     = slot_q;
    link_wdata     = '0;
    freed_we       = 1'b0;
    case (state_q)
      cht_pkg::StIdle: begin
        shift_d      = key_i;
        rem_d        = '0;
        prev_ok_d    = 1'b0;
        prev_d       = '0;
        hit_d        = 1'b0;
        res_status_d = cht_pkg::StOk;
        res_found_d  = '0;
      end
      cht_pkg::StDiv: begin
        shift_d = {shift_q[cht_pkg::KeyBits-2:0], 1'b0};
        if (rem_sh >= (cht_pkg::BucketBits+1)'(divisor)) begin
          rem_d = cht_pkg::BucketBits'(rem_sh - (cht_pkg::BucketBits+1)'(divisor));
        end else begin
          rem_d = cht_pkg::BucketBits'(rem_sh);
        end
      end
      cht_pkg::StHead: begin
        if (head_vld_q[rem_q]) begin
          ent_re    = 1'b1;
          ent_raddr = head_rd_q;
          cur_d     = head_rd_q;
        end
      end
      cht_pkg::StEntry: begin
        if (key_match) begin
          hit_d = 1'b1;
        end else begin
          prev_ok_d = 1'b1;
          prev_d    = cur_q;
          if (link_rd_q.vld) begin
            ent_re    = 1'b1;
            ent_raddr = link_rd_q.idx;
            cur_d     = link_rd_q.idx;
          end
        end
      end
      cht_pkg::StAct: begin
        case (cmd_q)
          cht_pkg::CmdLookup: begin
            if (hit_q) begin
              res_found_d = 32'(val_rd_q);
            end else begin
              res_status_d = cht_pkg::StNotFound;
            end
          end
          cht_pkg::CmdInsert: begin
            if (hit_q) begin
              res_status_d = cht_pkg::StDuplicate;
            end else if (pool_empty) begin
              res_status_d = cht_pkg::StPoolFull;
            end else if (freed_cnt_q != '0) begin
              // Recycled slots sit on top of the never-used ones.
              freed_re    = 1'b1;
              freed_raddr = cht_pkg::PoolBits'(freed_cnt_q - 1'b1);
              freed_cnt_d = freed_cnt_q - 1'b1;
            end else begin
              slot_d  = fresh_q[cht_pkg::PoolBits-1:0];
              fresh_d = fresh_q + 1'b1;
            end
          end
          cht_pkg::CmdDelete: begin
            if (!hit_q) begin
              res_status_d = cht_pkg::StNotFound;
            end else begin
              res_found_d = 32'(val_rd_q);
              if (prev_ok_q) begin
                link_we    = 1'b1;
                link_waddr = prev_q;
                link_wdata = link_rd_q;
              end else begin
                head_we        = 1'b1;
                head_wdata     = link_rd_q.idx;
                head_vld_wdata = link_rd_q.vld;
              end
              freed_we    = 1'b1;
              freed_cnt_d = freed_cnt_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      cht_pkg::StPop: slot_d = freed_rd_q;
      cht_pkg::StAlloc: begin
        ent_we     = 1'b1;
        link_we    = 1'b1;
        link_waddr = slot_q;
        link_wdata = '0;
        if (!prev_ok_q) begin
          head_we    = 1'b1;
          head_wdata = slot_q;
        end
      end
      cht_pkg::StLink: begin
        link_we        = 1'b1;
        link_waddr     = prev_q;
        link_wdata.vld = 1'b1;
        link_wdata.idx = slot_q;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cht_pkg::StIdle;
      step_q      <= '0;
      freed_cnt_q <= '0;
      fresh_q     <= '0;
      head_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      freed_cnt_q <= freed_cnt_d;
      fresh_q     <= fresh_d;
      step_q      <= (state_q == cht_pkg::StDiv) ? step_q + 1'b1 : '0;
      if (head_we) begin
        head_vld_q[rem_q] <= head_vld_wdata;
      end
      if (state_q == cht_pkg::StFin && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == cht_pkg::StIdle && in_valid_i) begin
      cmd_q <= cht_pkg::cmd_e'(command_i);
      key_q <= key_i;
      val_q <= cht_pkg::ValueBits'(value_i);
    end
    shift_q      <= shift_d;
    rem_q        <= rem_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_ok_q    <= prev_ok_d;
    hit_q        <= hit_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    if (state_q == cht_pkg::StFin && (!out_valid_q || out_ready_i)) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
    end
  end

  // Memories: bucket heads, entry keys, values and links, recycled slots.
  logic [cht_pkg::PoolBits-1:0]  head_mem  [cht_pkg::MaxBuckets];
  logic [cht_pkg::KeyBits-1:0]   key_mem   [cht_pkg::PoolEntries];
  logic [cht_pkg::ValueBits-1:0] val_mem   [cht_pkg::PoolEntries];
  cht_pkg::link_t                link_mem  [cht_pkg::PoolEntries];
  logic [cht_pkg::PoolBits-1:0]  freed_mem [cht_pkg::PoolEntries];

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[rem_q] <= head_wdata;
    end
    if (state_q == cht_pkg::StHeadRd) begin
      head_rd_q <= head_mem[rem_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      key_mem[slot_q] <= key_q;
      val_mem[slot_q] <= val_q;
    end
    if (ent_re) begin
      key_rd_q <= key_mem[ent_raddr];
      val_rd_q <= val_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ent_re) begin
      link_rd_q <= link_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (freed_we) begin
      freed_mem[freed_cnt_q[cht_pkg::PoolBits-1:0]] <= cur_q;
    end
    if (freed_re) begin
      freed_rd_q <= freed_mem[freed_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_found_q;

  // Checks.
  a_freed_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freed_cnt_q <= fresh_q)
    else $error("more recycled slots than slots ever handed out");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cht_pkg::StHeadRd |-> (cht_pkg::BktCntBits'(rem_q) < divisor))
    else $error("bucket index not below the bucket count");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cht_pkg::StFin && out_valid_q && !out_ready_i)
      |=> state_q == cht_pkg::StFin)
    else $error("result dropped while the output register was full");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second command taken while one is in flight");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the chained hash table unit.
// Depends on cht_pkg and chained_hash_table_unit; a predictor mirrors the table.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 1500000;

  typedef struct {
    cht_pkg::cmd_e    cmd;
    logic [31:0]      key;
    logic [31:0]      val;
    logic             has_exp;
    cht_pkg::status_e exp_status;
    logic [31:0]      exp_value;
  } stim_t;

  typedef struct {
    cht_pkg::status_e status;
    logic [31:0]      value;
  } answer_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [cht_pkg::BktCntBits-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] command_i;
  logic [31:0] key_i, value_i;
  logic out_valid_o, out_ready_i;
  logic [1:0] status_o;
  logic [31:0] found_value_o;

  chained_hash_table_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .command_i, .key_i, .value_i,
    .out_valid_o, .out_ready_i, .status_o, .found_value_o
  );

  // Predictor state: chains kept as queues of slot indices per bucket.
  int unsigned shadow_buckets;
  int unsigned chain_slots[cht_pkg::MaxBuckets][$];
  logic [31:0] slot_key[cht_pkg::PoolEntries];
  logic [31:0] slot_val[cht_pkg::PoolEntries];
  int unsigned free_slots[$];

  answer_t     answers_due[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          quiet_side;
  logic [31:0] live_keys[$];

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Cycle counter with the run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void reset_table();
    shadow_buckets = cht_pkg::MaxBuckets;
    for (int i = 0; i < cht_pkg::MaxBuckets; i++) chain_slots[i].delete();
    free_slots.delete();
    // Slot 0 is allocated first; the back of the queue is the stack top.
    for (int i = cht_pkg::PoolEntries - 1; i >= 0; i--) free_slots.push_back(i);
  endfunction

  function automatic answer_t predict_table(cht_pkg::cmd_e cmd, logic [31:0] key,
                                            logic [31:0] val);
    answer_t a;
    int unsigned n;
    int unsigned b;
    int hit_pos;
    int unsigned slot;
    n = (shadow_buckets == 0) ? 1 : (shadow_buckets > cht_pkg::MaxBuckets ?
                                     cht_pkg::MaxBuckets : shadow_buckets);
    b = key % n;
    a.status = cht_pkg::StOk;
    a.value = '0;
    hit_pos = -1;
    for (int i = 0; i < chain_slots[b].size(); i++) begin
      if (hit_pos < 0 && slot_key[chain_slots[b][i]] == key) hit_pos = i;
    end
    case (cmd)
      cht_pkg::CmdLookup: begin
        if (hit_pos >= 0) a.value = slot_val[chain_slots[b][hit_pos]];
        else a.status = cht_pkg::StNotFound;
      end
      cht_pkg::CmdInsert: begin
        if (hit_pos >= 0) a.status = cht_pkg::StDuplicate;
        else if (free_slots.size() == 0) a.status = cht_pkg::StPoolFull;
        else begin
          slot = free_slots.pop_back();
          slot_key[slot] = key;
          slot_val[slot] = val;
          chain_slots[b].push_back(slot);
        end
      end
      cht_pkg::CmdDelete: begin
        if (hit_pos < 0) a.status = cht_pkg::StNotFound;
        else begin
          slot = chain_slots[b][hit_pos];
          a.value = slot_val[slot];
          chain_slots[b].delete(hit_pos);
          free_slots.push_back(slot);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Receiver: random stalls, compare each accepted word with the oldest answer.
  always @(negedge clk_i) begin
    out_ready_i <= quiet_side ? 1'b1 : ($urandom_range(99) >= 17);
  end

  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answers_due.size() == 0) begin
        $error("result word with no answer pending");
        error_count++;
      end else begin
        exp_a = answers_due.pop_front();
        if (status_o !== exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, status_o);
          error_count++;
        end
        if (found_value_o !== exp_a.value) begin
          $error("found_value: expected %h, got %h", exp_a.value, found_value_o);
          error_count++;
        end
      end
    end
  end

  // Drive one word; valid stays up after acceptance until the next falling edge.
  task automatic send_word(stim_t s);
    answer_t a;
    @(negedge clk_i);
    while (!quiet_side && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    a = predict_table(s.cmd, s.key, s.val);
    if (s.has_exp && (a.status != s.exp_status || a.value != s.exp_value)) begin
      $error("directed row disagrees with predictor for key %h", s.key);
      error_count++;
    end
    answers_due.push_back(a);
    in_valid_i <= 1'b1;
    command_i  <= s.cmd;
    key_i      <= s.key;
    value_i    <= s.val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic write_buckets(logic [cht_pkg::BktCntBits-1:0] n);
    idle_input();
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= n;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_buckets = n;
  endtask

  function automatic stim_t row(cht_pkg::cmd_e c, logic [31:0] k, logic [31:0] v,
                                logic e, cht_pkg::status_e es, logic [31:0] ev);
    stim_t s;
    s.cmd = c; s.key = k; s.val = v; s.has_exp = e;
    s.exp_status = es; s.exp_value = ev;
    return s;
  endfunction

  task automatic random_phase(int unsigned count, int unsigned key_span);
    stim_t s;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      s.has_exp = 1'b0;
      s.val = $urandom();
      if (live_keys.size() != 0 && pick < 60)
        s.key = live_keys[$urandom_range(live_keys.size() - 1)];
      else if (pick < 85) s.key = $urandom_range(key_span);
      else s.key = $urandom();
      pick = $urandom_range(99);
      s.cmd = pick < 40 ? cht_pkg::CmdInsert : pick < 70 ? cht_pkg::CmdLookup :
              pick < 97 ? cht_pkg::CmdDelete : cht_pkg::CmdNop;
      if (s.cmd == cht_pkg::CmdInsert) live_keys.push_back(s.key);
      if (live_keys.size() > 64) void'(live_keys.pop_front());
      send_word(s);
    end
  endtask

  initial begin
    stim_t table_rows[$];
    cycle_count = 0;
    error_count = 0;
    quiet_side  = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    command_i   = cht_pkg::CmdNop;
    key_i       = '0;
    value_i     = '0;
    out_ready_i = 1'b0;
    reset_table();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: empty table, extremes, duplicates, chain middle delete.
    table_rows.push_back(row(cht_pkg::CmdLookup, 32'h0, 32'h0, 1'b1,
                             cht_pkg::StNotFound, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdDelete, 32'hFFFFFFFF, 32'h0, 1'b1,
                             cht_pkg::StNotFound, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdInsert, 32'h0, 32'hFFFFFFFF, 1'b1,
                             cht_pkg::StOk, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdInsert, 32'hFFFFFFFF, 32'h0, 1'b1,
                             cht_pkg::StOk, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdInsert, 32'h0, 32'h1234, 1'b1,
                             cht_pkg::StDuplicate, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdLookup, 32'h0, 32'h0, 1'b1,
                             cht_pkg::StOk, 32'hFFFFFFFF));
    table_rows.push_back(row(cht_pkg::CmdLookup, 32'hFFFFFFFF, 32'h5A5A, 1'b1,
                             cht_pkg::StOk, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdNop, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
                             cht_pkg::StOk, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdInsert, 32'h100, 32'hAAAA5555, 1'b0,
                             cht_pkg::StOk, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdInsert, 32'h200, 32'h5555AAAA, 1'b0,
                             cht_pkg::StOk, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdDelete, 32'h100, 32'h0, 1'b0,
                             cht_pkg::StOk, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdLookup, 32'h200, 32'h0, 1'b0,
                             cht_pkg::StOk, 32'h0));
    table_rows.push_back(row(cht_pkg::CmdDelete, 32'h0, 32'h0, 1'b1,
                             cht_pkg::StOk, 32'hFFFFFFFF));
    table_rows.push_back(row(cht_pkg::CmdLookup, 32'h0, 32'h0, 1'b1,
                             cht_pkg::StNotFound, 32'h0));
    foreach (table_rows[i]) send_word(table_rows[i]);

    // Bucket count zero acts as one: everything lands on one chain.
    write_buckets(9'd0);
    random_phase(50, 40);
    // Stored entries stay in old chains after a change of bucket count.
    write_buckets(9'd1);
    random_phase(40, 40);
    write_buckets(9'd511);
    random_phase(60, 1000);
    quiet_side = 1'b1;
    write_buckets(9'd7);
    random_phase(60, 100);
    quiet_side = 1'b0;
    write_buckets(9'd256);
    random_phase(60, 2000);
    write_buckets(9'd255);
    random_phase(110, 300);

    idle_input();
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
